// File: hdl/wrpc_pkg.sv
package wrpc_pkg;

  localparam int MAX_LEN = 1024;
  localparam logic [29:0] MODULUS = 30'd1000000007;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               first_item;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic [29:0] ways;
    logic        is_final;
    logic        overflow;
  } out_t;

  // a - b modulo the prime, both operands already reduced
  function automatic logic [29:0] mod_sub(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    end
    return t[29:0];
  endfunction

  // a + b modulo the prime, both operands already reduced
  function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, MODULUS}) begin
      t = t - {1'b0, MODULUS};
    end
    return t[29:0];
  endfunction

endpackage

// File: hdl/wrpc_ram.sv
module wrpc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/window_range_partition_count_core.sv
// sequence: pop dominated tail entries, push, shrink the window one step at a time, then
//   update the prefix sum; an overflowed item goes straight to the result register
// throughput: one transaction at a time, no new sample is taken until the result is
//   registered for output, paced by the one-read-port queue memories walked by the loops
// reset: synchronous active-low rst_n empties the window and clears max_difference;
//   memories are not cleared, only entries written in the current sequence are read
module window_range_partition_count_core #(
  parameter int MAX_LEN = wrpc_pkg::MAX_LEN
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wrpc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wrpc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [30:0]    cfg_data
);

  // queue index width and counter width (counters can reach MAX_LEN)
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int QW = AW + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_CMP, S_PUSH, S_HEAD_RD, S_SHRINK, S_PF_RD, S_PF_CALC, S_DONE
  } state_t;

  state_t state_r;

  logic [30:0]    md_r;
  wrpc_pkg::in_t  item_r;
  wrpc_pkg::out_t res_r;
  wrpc_pkg::out_t out_data_r;
  logic           out_valid_r;

  logic [CW-1:0] min_head_r, min_tail_r, max_head_r, max_tail_r;
  logic [CW-1:0] ws_r, pos_r;
  logic          ovf_r;
  logic [29:0]   pref_last_r;   // prefix sum at the current position
  logic [29:0]   last_ways_r;   // count of the last accepted prefix
  logic          min_act_r, max_act_r, min_rd_r, max_rd_r;

  // queue memories hold {sample index, sample value}
  logic          q_we;
  logic [AW-1:0] minq_waddr, maxq_waddr, minq_raddr, maxq_raddr;
  logic [QW-1:0] minq_wdata, maxq_wdata, minq_rdata, maxq_rdata;

  // prefix memory
  logic          pf_we;
  logic [CW-1:0] pf_waddr, pf_raddr;
  logic [29:0]   pf_wdata, pf_rdata;

  // combinational helpers
  logic              accept;
  logic              min_go, max_go;
  logic signed [31:0] v, min_val, max_val;
  logic [AW-1:0]     min_idx, max_idx;
  logic signed [33:0] diff;
  logic [CW-1:0]     pos_eff;
  logic              ovf_eff;
  logic [29:0]       pf_sub, ways_c, sum_c;
  logic [CW-1:0]     min_tail_m1, max_tail_m1, ws_m2, pos_p1;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign v       = item_r.sample;
  assign min_val = minq_rdata[31:0];
  assign max_val = maxq_rdata[31:0];
  assign min_idx = minq_rdata[QW-1:32];
  assign max_idx = maxq_rdata[QW-1:32];
  // range formed wide enough that no wrap occurs
  assign diff    = {{2{max_val[31]}}, max_val} - {{2{min_val[31]}}, min_val};

  assign min_go = min_act_r && (min_tail_r > min_head_r);
  assign max_go = max_act_r && (max_tail_r > max_head_r);

  assign min_tail_m1 = min_tail_r - CW'(1);
  assign max_tail_m1 = max_tail_r - CW'(1);
  assign ws_m2       = ws_r - CW'(2);
  assign pos_p1      = pos_r + CW'(1);

  assign pos_eff = in_data.first_item ? '0 : pos_r;
  assign ovf_eff = in_data.first_item ? 1'b0 : ovf_r;

  // tail reads while popping, head reads otherwise
  always_comb begin
    if (state_r == S_POP_RD) begin
      minq_raddr = min_tail_m1[AW-1:0];
      maxq_raddr = max_tail_m1[AW-1:0];
    end else begin
      minq_raddr = min_head_r[AW-1:0];
      maxq_raddr = max_head_r[AW-1:0];
    end
  end

  assign q_we       = (state_r == S_PUSH);
  assign minq_waddr = min_tail_r[AW-1:0];
  assign maxq_waddr = max_tail_r[AW-1:0];
  assign minq_wdata = {pos_r[AW-1:0], v};
  assign maxq_wdata = {pos_r[AW-1:0], v};

  // prefix term below the window: none, the constant one, or a stored entry
  always_comb begin
    if (ws_r < CW'(2)) begin
      pf_sub = '0;
    end else if (ws_r == CW'(2)) begin
      pf_sub = 30'd1;
    end else begin
      pf_sub = pf_rdata;
    end
  end

  assign ways_c   = wrpc_pkg::mod_sub(pref_last_r, pf_sub);
  assign sum_c    = wrpc_pkg::mod_add(pref_last_r, ways_c);
  assign pf_raddr = ws_m2;
  assign pf_we    = (state_r == S_PF_CALC);
  assign pf_waddr = pos_p1;
  assign pf_wdata = sum_c;

  wrpc_ram #(.DEPTH(MAX_LEN), .WIDTH(QW)) u_min_q (
    .clk(clk), .we(q_we), .waddr(minq_waddr), .wdata(minq_wdata),
    .raddr(minq_raddr), .rdata(minq_rdata)
  );

  wrpc_ram #(.DEPTH(MAX_LEN), .WIDTH(QW)) u_max_q (
    .clk(clk), .we(q_we), .waddr(maxq_waddr), .wdata(maxq_wdata),
    .raddr(maxq_raddr), .rdata(maxq_rdata)
  );

  wrpc_ram #(.DEPTH(MAX_LEN + 1), .WIDTH(30)) u_prefix (
    .clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(pf_wdata),
    .raddr(pf_raddr), .rdata(pf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      md_r        <= '0;
      out_valid_r <= 1'b0;
      min_head_r  <= '0;
      min_tail_r  <= '0;
      max_head_r  <= '0;
      max_tail_r  <= '0;
      ws_r        <= CW'(1);
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      pref_last_r <= 30'd1;
      min_act_r   <= 1'b0;
      max_act_r   <= 1'b0;
      min_rd_r    <= 1'b0;
      max_rd_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        md_r <= cfg_data;
      end
      // result register drains independently of the sequencer
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            if (in_data.first_item) begin
              // new sequence empties the window
              min_head_r  <= '0;
              min_tail_r  <= '0;
              max_head_r  <= '0;
              max_tail_r  <= '0;
              ws_r        <= CW'(1);
              pos_r       <= '0;
              ovf_r       <= 1'b0;
              pref_last_r <= 30'd1;
            end
            if (ovf_eff || (pos_eff >= CW'(MAX_LEN))) begin
              // too long: sample dropped, last count held
              ovf_r          <= 1'b1;
              res_r.ways     <= (pos_eff >= CW'(1)) ? last_ways_r : '0;
              res_r.is_final <= in_data.last_item;
              res_r.overflow <= 1'b1;
              state_r        <= S_DONE;
            end else begin
              min_act_r <= 1'b1;
              max_act_r <= 1'b1;
              state_r   <= S_POP_RD;
            end
          end
        end
        S_POP_RD: begin
          min_act_r <= min_go;
          max_act_r <= max_go;
          min_rd_r  <= min_go;
          max_rd_r  <= max_go;
          state_r   <= (min_go || max_go) ? S_POP_CMP : S_PUSH;
        end
        S_POP_CMP: begin
          // drop tail entries dominated by the new sample
          if (min_rd_r) begin
            if (min_val >= v) begin
              min_tail_r <= min_tail_m1;
            end else begin
              min_act_r <= 1'b0;
            end
          end
          if (max_rd_r) begin
            if (max_val <= v) begin
              max_tail_r <= max_tail_m1;
            end else begin
              max_act_r <= 1'b0;
            end
          end
          state_r <= S_POP_RD;
        end
        S_PUSH: begin
          min_tail_r <= min_tail_r + CW'(1);
          max_tail_r <= max_tail_r + CW'(1);
          state_r    <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          state_r <= S_SHRINK;
        end
        S_SHRINK: begin
          if (diff > $signed({3'b000, md_r})) begin
            // one step of the window start, heads retire entries left behind
            ws_r <= ws_r + CW'(1);
            if (({1'b0, min_idx} < {1'b0, ws_r[AW-1:0]} || ws_r > CW'(MAX_LEN - 1))
                && ((min_head_r + CW'(1)) < min_tail_r)) begin
              min_head_r <= min_head_r + CW'(1);
            end
            if (({1'b0, max_idx} < {1'b0, ws_r[AW-1:0]} || ws_r > CW'(MAX_LEN - 1))
                && ((max_head_r + CW'(1)) < max_tail_r)) begin
              max_head_r <= max_head_r + CW'(1);
            end
            state_r <= S_HEAD_RD;
          end else begin
            state_r <= S_PF_RD;
          end
        end
        S_PF_RD: begin
          state_r <= S_PF_CALC;
        end
        S_PF_CALC: begin
          pref_last_r    <= sum_c;
          last_ways_r    <= ways_c;
          pos_r          <= pos_p1;
          res_r.ways     <= ways_c;
          res_r.is_final <= item_r.last_item;
          res_r.overflow <= 1'b0;
          state_r        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // position never runs past the sample capacity
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CW'(MAX_LEN)) else $error("position beyond capacity");

  // window start never passes the newest sample
  a_ws_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ws_r} <= {1'b0, pos_r} + 1'b1) else $error("window start past newest sample");

  // queues are never empty while the window is shrunk
  a_q_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHRINK) |-> (min_head_r < min_tail_r) && (max_head_r < max_tail_r))
    else $error("empty queue during window shrink");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
